// ----- sv/igq_pkg.sv -----
// Shared types, constants and helper functions for the IGMPv2 querier engine.
package igq_pkg;

	localparam int GROUPS    = 16;
	localparam int IDX_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_QUERY  = 2'd1,
		OP_REPORT = 2'd2,
		OP_LEAVE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		K_GENERAL = 2'd0,
		K_GROUP   = 2'd1,
		K_EXPIRED = 2'd2,
		K_FULL    = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MY_ADDRESS    = 3'd0,
		CFG_ROBUSTNESS    = 3'd1,
		CFG_QUERY_IVL     = 3'd2,
		CFG_QRESP_TENTHS  = 3'd3,
		CFG_LMEMB_TENTHS  = 3'd4
	} cfg_idx_t;

	// Datapath operation selected by the controller for the current cycle.
	typedef enum logic [2:0] {
		ST_NONE,
		ST_GLOBAL,
		ST_LM,
		ST_MB,
		ST_FIND,
		ST_APPLY,
		ST_FLUSH
	} step_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GLOBAL,
		S_LM,
		S_MB,
		S_FIND,
		S_APPLY,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic  capture;
		step_t step;
		logic  idx_clr;
		logic  idx_inc;
	} cmd_t;

	typedef struct packed {
		logic step_ok;
		logic idx_last;
	} sts_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] group;
		logic [4:0]  mr;
	} res_t;

	// Tenths to whole seconds: multiply by reciprocal, exact for 8-bit input.
	function automatic logic [4:0] qr_sec(input logic [7:0] tenths);
		logic [15:0] p;
		p = 16'(tenths) * 16'd205;
		return 5'(p >> 11);
	endfunction

	function automatic logic [4:0] lm_sec(input logic [7:0] tenths);
		logic [4:0] s;
		s = qr_sec(tenths);
		return (s == 5'd0) ? 5'd1 : s;
	endfunction

	function automatic logic [2:0] eff_r(input logic [2:0] r);
		return (r == 3'd0) ? 3'd1 : r;
	endfunction

endpackage

// ----- sv/igq_if.sv -----
// Valid/ready channel interfaces for the input and result streams.
interface igq_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] source_address;
	logic [31:0] group_address;
	modport source(output valid, opcode, source_address, group_address, input ready);
	modport sink(input valid, opcode, source_address, group_address, output ready);
endinterface

interface igq_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [31:0] result_group;
	logic [4:0]  max_response_seconds;
	logic        querier_now;
	logic [31:0] current_querier;
	logic        last_of_run;
	modport source(output valid, result_kind, result_group, max_response_seconds,
		querier_now, current_querier, last_of_run, input ready);
	modport sink(input valid, result_kind, result_group, max_response_seconds,
		querier_now, current_querier, last_of_run, output ready);
endinterface

// ----- sv/igq_ctrl.sv -----
// Controller state machine sequencing timer, table scan and result flush steps.
module igq_ctrl import igq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_opcode,
	output logic       in_ready,
	output cmd_t       cmd,
	input  sts_t       sts
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (op_t'(in_opcode))
						OP_TICK:  state_nxt = S_GLOBAL;
						OP_QUERY: state_nxt = S_APPLY;
						default:  state_nxt = S_FIND;
					endcase
				end
			end
			S_GLOBAL: if (sts.step_ok) state_nxt = S_LM;
			S_LM:     if (sts.step_ok) state_nxt = S_MB;
			S_MB: begin
				if (sts.step_ok) state_nxt = sts.idx_last ? S_FLUSH : S_LM;
			end
			S_FIND:   if (sts.idx_last) state_nxt = S_APPLY;
			S_APPLY:  if (sts.step_ok) state_nxt = S_FLUSH;
			S_FLUSH:  if (sts.step_ok) state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.step    = ST_NONE;
		cmd.idx_clr = 1'b0;
		cmd.idx_inc = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				cmd.idx_clr = 1'b1;
			end
			S_GLOBAL: cmd.step = ST_GLOBAL;
			S_LM:     cmd.step = ST_LM;
			S_MB: begin
				cmd.step    = ST_MB;
				cmd.idx_inc = sts.step_ok && !sts.idx_last;
			end
			S_FIND: begin
				cmd.step    = ST_FIND;
				cmd.idx_inc = !sts.idx_last;
			end
			S_APPLY:  cmd.step = ST_APPLY;
			S_FLUSH:  cmd.step = ST_FLUSH;
			default:  cmd.step = ST_NONE;
		endcase
	end

endmodule

// ----- sv/igq_dpath.sv -----
// Datapath: configuration, querier timers, group table and result registers.
module igq_dpath import igq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [1:0]           in_opcode,
	input  logic [31:0]          in_source,
	input  logic [31:0]          in_group,
	igq_out_if.source            out_ch
);

	// configuration
	logic [31:0] my_addr_q;
	logic [2:0]  rob_q;
	logic [15:0] qi_q;
	logic [7:0]  qrt_q;
	logic [7:0]  lmt_q;

	// captured item
	op_t         op_q;
	logic [31:0] src_q;
	logic [31:0] grp_q;
	logic [IDX_W-1:0] idx_q;

	// querier state
	logic        is_q_q;
	logic [31:0] qaddr_q;
	logic        startup_q;
	logic [2:0]  sleft_q;
	logic        general_q;
	logic [15:0] qcnt_q;
	logic [18:0] oqc_q;

	// group table
	logic [GROUPS-1:0] valid_q;
	logic [31:0] grp_mem [GROUPS];
	logic [18:0] mbc_mem [GROUPS];
	logic [4:0]  lmc_mem [GROUPS];
	logic [2:0]  lml_mem [GROUPS];

	// lookup results
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             free_v_q;
	logic [IDX_W-1:0] free_idx_q;

	// result staging
	logic        pend_v_q;
	res_t        pend_q;
	logic        out_v_q;
	res_t        out_q;
	logic        out_last_q;
	logic        out_qnow_q;
	logic [31:0] out_qaddr_q;

	logic [2:0]  r_eff;
	logic [4:0]  qrs;
	logic [4:0]  lms;
	logic [18:0] rqi;
	logic [18:0] gm_ivl;
	logic [18:0] oq_sum;
	logic [18:0] oq_ivl;
	logic [18:0] rlm;

	logic        e_v;
	logic [31:0] e_grp;
	logic [18:0] e_mbc;
	logic [4:0]  e_lmc;
	logic [2:0]  e_lml;

	logic        oq_fire;
	logic        emit_req;
	res_t        emit_res;
	logic        out_free;
	logic        can_emit;
	logic        step_ok;
	logic        load_out;
	logic        slot_ok;
	logic [IDX_W-1:0] slot;
	logic        leave_ok;

	assign r_eff  = eff_r(rob_q);
	assign qrs    = qr_sec(qrt_q);
	assign lms    = lm_sec(lmt_q);
	assign rqi    = 19'(r_eff) * 19'(qi_q);
	assign gm_ivl = rqi + 19'(qrs);
	assign oq_sum = rqi + 19'(qrs >> 1);
	assign oq_ivl = (oq_sum == 19'd0) ? 19'd1 : oq_sum;
	assign rlm    = 19'(8'(r_eff) * 8'(lms));

	assign e_v   = valid_q[idx_q];
	assign e_grp = grp_mem[idx_q];
	assign e_mbc = mbc_mem[idx_q];
	assign e_lmc = lmc_mem[idx_q];
	assign e_lml = lml_mem[idx_q];

	assign oq_fire  = (oqc_q != 19'd0) && (oqc_q <= 19'd1);
	assign slot_ok  = hit_q || free_v_q;
	assign slot     = hit_q ? hit_idx_q : free_idx_q;
	assign leave_ok = is_q_q && hit_q;

	always_comb begin
		emit_req = 1'b0;
		emit_res = '{kind: K_GENERAL, group: 32'd0, mr: qrs};
		case (cmd.step)
			ST_GLOBAL: begin
				emit_req = oq_fire || ((startup_q || general_q) && qcnt_q <= 16'd1);
			end
			ST_LM: begin
				emit_req = e_v && e_lmc == 5'd1;
				emit_res = '{kind: K_GROUP, group: e_grp, mr: lms};
			end
			ST_MB: begin
				emit_req = e_v && e_mbc <= 19'd1;
				emit_res = '{kind: K_EXPIRED, group: e_grp, mr: 5'd0};
			end
			ST_APPLY: begin
				case (op_q)
					OP_REPORT: begin
						emit_req = !slot_ok;
						emit_res = '{kind: K_FULL, group: grp_q, mr: 5'd0};
					end
					OP_LEAVE: begin
						emit_req = leave_ok;
						emit_res = '{kind: K_GROUP, group: grp_q, mr: lms};
					end
					default: emit_req = 1'b0;
				endcase
			end
			default: emit_req = 1'b0;
		endcase
	end

	assign out_free = !out_v_q || out_ch.ready;
	assign can_emit = !pend_v_q || out_free;
	assign step_ok  = (cmd.step == ST_FLUSH) ? can_emit : (!emit_req || can_emit);
	assign load_out = pend_v_q && out_free && (emit_req || cmd.step == ST_FLUSH);

	assign sts.step_ok  = step_ok;
	assign sts.idx_last = (idx_q == IDX_W'(GROUPS - 1));

	// Capture the item, walk the table index and hold the lookup results.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(in_opcode);
			src_q <= in_source;
			grp_q <= in_group;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.step == ST_FIND) begin
			if (e_v && e_grp == grp_q && !hit_q) hit_idx_q <= idx_q;
			if (!e_v && !free_v_q) free_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q    <= 1'b0;
			free_v_q <= 1'b0;
		end else if (cmd.capture) begin
			hit_q    <= 1'b0;
			free_v_q <= 1'b0;
		end else if (cmd.step == ST_FIND) begin
			if (e_v && e_grp == grp_q) hit_q <= 1'b1;
			if (!e_v) free_v_q <= 1'b1;
		end
	end

	// Configuration and querier timers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_addr_q <= 32'd0;
			rob_q     <= 3'd2;
			qi_q      <= 16'd125;
			qrt_q     <= 8'd100;
			lmt_q     <= 8'd10;
			is_q_q    <= 1'b1;
			qaddr_q   <= 32'd0;
			startup_q <= 1'b1;
			sleft_q   <= 3'd1;
			general_q <= 1'b0;
			qcnt_q    <= 16'd31;
			oqc_q     <= 19'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MY_ADDRESS: begin
						my_addr_q <= cfg_data;
						if (is_q_q) qaddr_q <= cfg_data;
					end
					CFG_ROBUSTNESS:   rob_q <= cfg_data[2:0];
					CFG_QUERY_IVL:    qi_q  <= cfg_data[15:0];
					CFG_QRESP_TENTHS: qrt_q <= cfg_data[7:0];
					CFG_LMEMB_TENTHS: lmt_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.step == ST_GLOBAL && step_ok) begin
				if (oq_fire) begin
					oqc_q     <= 19'd0;
					is_q_q    <= 1'b1;
					qaddr_q   <= my_addr_q;
					general_q <= 1'b1;
					startup_q <= 1'b0;
					qcnt_q    <= qi_q;
				end else begin
					if (oqc_q != 19'd0) oqc_q <= oqc_q - 19'd1;
					if (startup_q || general_q) begin
						if (qcnt_q <= 16'd1) begin
							if (startup_q && sleft_q > 3'd1) begin
								sleft_q <= sleft_q - 3'd1;
								qcnt_q  <= qi_q >> 2;
							end else begin
								startup_q <= 1'b0;
								general_q <= 1'b1;
								qcnt_q    <= qi_q;
							end
						end else begin
							qcnt_q <= qcnt_q - 16'd1;
						end
					end
				end
			end
			if (cmd.step == ST_APPLY && op_q == OP_QUERY && src_q < my_addr_q) begin
				is_q_q    <= 1'b0;
				qaddr_q   <= src_q;
				startup_q <= 1'b0;
				general_q <= 1'b0;
				oqc_q     <= oq_ivl;
			end
		end
	end

	// Entry valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.step == ST_MB && step_ok && e_v && e_mbc <= 19'd1) begin
			valid_q[idx_q] <= 1'b0;
		end else if (cmd.step == ST_APPLY && op_q == OP_REPORT && slot_ok) begin
			valid_q[slot] <= 1'b1;
		end
	end

	// Entry payload: scan updates at the walk index, item updates at the slot.
	always_ff @(posedge clk) begin
		if (cmd.step == ST_LM && step_ok && e_v && e_lmc != 5'd0) begin
			if (e_lmc == 5'd1) begin
				lmc_mem[idx_q] <= (e_lml > 3'd1) ? lms : 5'd0;
				lml_mem[idx_q] <= (e_lml > 3'd1) ? e_lml - 3'd1 : 3'd0;
			end else begin
				lmc_mem[idx_q] <= e_lmc - 5'd1;
			end
		end
		if (cmd.step == ST_MB && step_ok && e_v) begin
			if (e_mbc <= 19'd1) begin
				mbc_mem[idx_q] <= 19'd0;
				lmc_mem[idx_q] <= 5'd0;
				lml_mem[idx_q] <= 3'd0;
			end else begin
				mbc_mem[idx_q] <= e_mbc - 19'd1;
			end
		end
		if (cmd.step == ST_APPLY) begin
			if (op_q == OP_REPORT && slot_ok) begin
				grp_mem[slot] <= grp_q;
				mbc_mem[slot] <= gm_ivl;
				lmc_mem[slot] <= 5'd0;
				lml_mem[slot] <= 3'd0;
			end else if (op_q == OP_LEAVE && leave_ok) begin
				mbc_mem[hit_idx_q] <= rlm;
				lmc_mem[hit_idx_q] <= lms;
				lml_mem[hit_idx_q] <= r_eff - 3'd1;
			end
		end
	end

	// One result held back so the final beat of an item can carry its mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit_req && step_ok) begin
				pend_v_q <= 1'b1;
			end else if (cmd.step == ST_FLUSH && out_free) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req && step_ok) pend_q <= emit_res;
		if (load_out) begin
			out_q       <= pend_q;
			out_last_q  <= (cmd.step == ST_FLUSH);
			out_qnow_q  <= is_q_q;
			out_qaddr_q <= qaddr_q;
		end
	end

	assign out_ch.valid                = out_v_q;
	assign out_ch.result_kind          = out_q.kind;
	assign out_ch.result_group         = out_q.group;
	assign out_ch.max_response_seconds = out_q.mr;
	assign out_ch.querier_now          = out_qnow_q;
	assign out_ch.current_querier      = out_qaddr_q;
	assign out_ch.last_of_run          = out_last_q;

	// A new item never starts with a result still held back.
	a_capture_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !pend_v_q)
		else $error("item accepted with a result still pending");

	// The other-querier timer runs exactly while another router is querier.
	a_oq_running: assert property (@(posedge clk) disable iff (!arst_n)
		is_q_q == (oqc_q == 19'd0))
		else $error("querier flag and other-querier timer disagree");

	// While querier, the recorded querier is this router.
	a_own_addr: assert property (@(posedge clk) disable iff (!arst_n)
		is_q_q |-> (qaddr_q == my_addr_q))
		else $error("querier address differs from own address");

	// Startup and general query timers never run together.
	a_timer_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(startup_q && general_q))
		else $error("startup and general timers both active");

endmodule

// ----- sv/igmpv2_querier_membership_engine_core.sv -----
// Top level of the IGMPv2 router querier and group membership engine.
//
// Channels: in_ch carries one beat per received event (one-second tick,
// membership query, v2 report, leave); out_ch carries result beats (general
// query, group-specific query, group expiry, table full). Both use
// valid/ready; a beat moves on a clock edge where both are high. The cfg
// port writes one register per cycle with cfg_we, chosen by cfg_index.
//
// Items are handled one at a time. A query goes through the apply and
// flush steps; a report or leave first looks at all GROUPS entries (one
// table entry looked at per cycle), and a tick steps the querier timers,
// then takes each entry for the last-member timer and then the membership
// timer (GROUPS = 16). Walks use the single entry read port.
// Every result beat waits in a holding register until the next beat of the
// same item is produced or the walk ends, so the final beat of an item can
// carry last_of_run.
//
// Receiver stall: when out_ch.ready is low and both the output and holding
// registers are full, the walk pauses on the entry that wants to emit and
// resumes when the output frees. in_ch.ready rises again only after the
// last beat of the previous item has entered the output register.
// Reset: registers return to their defaults, the table is empty, the router
// is querier and the startup query sequence is armed.
module igmpv2_querier_membership_engine_core import igq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	igq_in_if.sink               in_ch,
	igq_out_if.source            out_ch
);

	cmd_t cmd;
	sts_t sts;

	// Sequence the per-item steps.
	igq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_opcode (in_ch.opcode),
		.in_ready  (in_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Hold the timers, the group table and the result registers.
	igq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_opcode (in_ch.opcode),
		.in_source (in_ch.source_address),
		.in_group  (in_ch.group_address),
		.out_ch    (out_ch)
	);

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the IGMPv2 querier and group membership engine.
module testbench;
	import igq_pkg::*;

	// Longest run of cycles with no beat on either channel before giving up.
	localparam int STALL_LIMIT = 4000;
	// Cycles to let a tick walk finish after its last result.
	localparam int WALK_CYCLES = 48;
	localparam int HOLD_OFF    = 300;

	typedef struct {
		kind_t       kind;
		logic [31:0] grp;
		logic [4:0]  mr;
		logic        qn;
		logic [31:0] cq;
		logic        last;
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	igq_in_if  in_ch();
	igq_out_if out_ch();

	igmpv2_querier_membership_engine_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	// Free-running clock, period 4.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Idling knobs, in percent, set per phase.
	int snd_idle_pct;
	int rcv_stall_pct;
	logic hold_req;
	int hold_left;
	int errors;
	int quiet_cycles;

	beat_t result_q[$];   // expected result beats, oldest first
	beat_t run_q[$];      // beats of the item being predicted
	logic [31:0] group_pool[20];

	// Predicted configuration.
	logic [31:0] m_my_addr;
	logic [2:0]  m_robust;
	logic [15:0] m_qi;
	logic [7:0]  m_qr_tenths;
	logic [7:0]  m_lm_tenths;
	// Predicted querier state.
	logic        m_querier;
	logic [31:0] m_querier_addr;
	logic        m_startup;
	logic [2:0]  m_startup_left;
	logic        m_general;
	logic [15:0] m_query_cnt;
	logic [18:0] m_other_cnt;
	// Predicted group table.
	logic        m_valid[GROUPS];
	logic [31:0] m_group[GROUPS];
	logic [18:0] m_member_cnt[GROUPS];
	logic [4:0]  m_lastmem_cnt[GROUPS];
	logic [2:0]  m_lastmem_left[GROUPS];

	function automatic int rob_eff();
		return (m_robust == 3'd0) ? 1 : int'(m_robust);
	endfunction

	function automatic int resp_secs();
		return int'(m_qr_tenths) / 10;
	endfunction

	function automatic int lastmem_secs();
		int s;
		s = int'(m_lm_tenths) / 10;
		return (s == 0) ? 1 : s;
	endfunction

	function automatic int find_entry(logic [31:0] g);
		for (int i = 0; i < GROUPS; i++)
			if (m_valid[i] && m_group[i] == g)
				return i;
		return -1;
	endfunction

	function automatic void push_beat(kind_t k, logic [31:0] g, int mr);
		beat_t b;
		b.kind = k;
		b.grp  = g;
		b.mr   = 5'(mr);
		b.qn   = 1'b0;
		b.cq   = '0;
		b.last = 1'b0;
		run_q.insert(run_q.size(), b);
	endfunction

	// Advance every timer by one second.
	function automatic void tick_second();
		logic other_fired;
		other_fired = 1'b0;
		if (m_other_cnt != 0) begin
			if (m_other_cnt <= 1) begin
				// other querier gone: take over and restart regular queries
				m_other_cnt    = '0;
				other_fired    = 1'b1;
				m_querier      = 1'b1;
				m_querier_addr = m_my_addr;
				push_beat(K_GENERAL, '0, resp_secs());
				m_general      = 1'b1;
				m_startup      = 1'b0;
				m_query_cnt    = m_qi;
			end else begin
				m_other_cnt--;
			end
		end
		if (!other_fired && (m_startup || m_general)) begin
			if (m_query_cnt <= 1) begin
				push_beat(K_GENERAL, '0, resp_secs());
				if (m_startup && m_startup_left > 1) begin
					m_startup_left--;
					m_query_cnt = m_qi / 4;
				end else begin
					m_startup   = 1'b0;
					m_general   = 1'b1;
					m_query_cnt = m_qi;
				end
			end else begin
				m_query_cnt--;
			end
		end
		for (int i = 0; i < GROUPS; i++) begin
			if (!m_valid[i])
				continue;
			if (m_lastmem_cnt[i] != 0) begin
				m_lastmem_cnt[i]--;
				if (m_lastmem_cnt[i] == 0) begin
					push_beat(K_GROUP, m_group[i], lastmem_secs());
					if (m_lastmem_left[i] > 1) begin
						m_lastmem_left[i]--;
						m_lastmem_cnt[i] = 5'(lastmem_secs());
					end else begin
						m_lastmem_left[i] = '0;
					end
				end
			end
			if (m_member_cnt[i] <= 1) begin
				// group-specific query (if any) goes out before the expiry
				push_beat(K_EXPIRED, m_group[i], 0);
				m_valid[i]        = 1'b0;
				m_lastmem_cnt[i]  = '0;
				m_lastmem_left[i] = '0;
				m_member_cnt[i]   = '0;
			end else begin
				m_member_cnt[i]--;
			end
		end
	endfunction

	// Work out the result beats of one accepted item and queue them.
	function automatic void predict_item(op_t op, logic [31:0] src, logic [31:0] grp);
		int j;
		int oq;
		run_q.delete();
		case (op)
			OP_TICK: tick_second();
			OP_QUERY: begin
				if (src < m_my_addr) begin
					oq = rob_eff() * int'(m_qi) + resp_secs() / 2;
					m_querier      = 1'b0;
					m_querier_addr = src;
					m_startup      = 1'b0;
					m_general      = 1'b0;
					m_other_cnt    = 19'((oq == 0) ? 1 : oq);
				end
			end
			OP_REPORT: begin
				j = find_entry(grp);
				if (j < 0) begin
					for (int i = 0; i < GROUPS; i++)
						if (!m_valid[i]) begin
							j = i;
							break;
						end
					if (j >= 0) begin
						m_valid[j] = 1'b1;
						m_group[j] = grp;
					end
				end
				if (j < 0) begin
					push_beat(K_FULL, grp, 0);
				end else begin
					m_member_cnt[j]   = 19'(rob_eff() * int'(m_qi) + resp_secs());
					m_lastmem_cnt[j]  = '0;
					m_lastmem_left[j] = '0;
				end
			end
			default: begin
				j = find_entry(grp);
				if (m_querier && j >= 0) begin
					m_member_cnt[j]   = 19'(rob_eff() * lastmem_secs());
					m_lastmem_cnt[j]  = 5'(lastmem_secs());
					m_lastmem_left[j] = 3'(rob_eff() - 1);
					push_beat(K_GROUP, grp, lastmem_secs());
				end
			end
		endcase
		foreach (run_q[k]) begin
			run_q[k].qn   = m_querier;
			run_q[k].cq   = m_querier_addr;
			run_q[k].last = (k == run_q.size() - 1);
			result_q.insert(result_q.size(), run_q[k]);
		end
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	// Offer one beat, with random idle cycles first, and hold it until taken.
	task automatic send_item(op_t op, logic [31:0] src, logic [31:0] grp);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.opcode         <= op;
		in_ch.source_address <= src;
		in_ch.group_address  <= grp;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_item(op, src, grp);
	endtask

	// Drop valid, wait out every expected beat, then let the walk finish.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (WALK_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_MY_ADDRESS: begin
				m_my_addr = data;
				if (m_querier)
					m_querier_addr = m_my_addr;
			end
			CFG_ROBUSTNESS:   m_robust    = data[2:0];
			CFG_QUERY_IVL:    m_qi        = data[15:0];
			CFG_QRESP_TENTHS: m_qr_tenths = data[7:0];
			default:          m_lm_tenths = data[7:0];
		endcase
	endtask

	task automatic set_config(logic [31:0] addr, int r, int qi, int qrt, int lmt);
		drain();
		write_reg(CFG_MY_ADDRESS, addr);
		write_reg(CFG_ROBUSTNESS, 32'(r));
		write_reg(CFG_QUERY_IVL, 32'(qi));
		write_reg(CFG_QRESP_TENTHS, 32'(qrt));
		write_reg(CFG_LMEMB_TENTHS, 32'(lmt));
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(int snd, int rcv);
		snd_idle_pct  = snd;
		rcv_stall_pct = rcv;
	endtask

	// Mostly pool groups so reports, leaves and expiries meet; some wild ones.
	function automatic logic [31:0] pick_group();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return group_pool[$urandom_range(0, 19)];
	endfunction

	// Query source below, at or above our own address, or anywhere.
	function automatic logic [31:0] pick_query_src();
		case ($urandom_range(0, 3))
			0: return (m_my_addr == 0) ? 32'd0 : $urandom_range(0, m_my_addr - 1);
			1: return m_my_addr;
			2: return (m_my_addr == '1) ? m_my_addr : $urandom_range(m_my_addr + 1, 32'hffffffff);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			send_item(OP_TICK, $urandom, $urandom);
		else if (pick < 70)
			send_item(OP_REPORT, $urandom, pick_group());
		else if (pick < 90)
			send_item(OP_LEAVE, $urandom, pick_group());
		else
			send_item(OP_QUERY, pick_query_src(), $urandom);
	endtask

	task automatic run_random(int count);
		repeat (count) send_random();
	endtask

	// Directed: extremes, every opcode, leave on unknown group, own-address
	// and higher-address queries, losing the election, leave as non-querier,
	// and the other querier timer running out.
	task automatic test_directed();
		set_config(32'h0a000005, 2, 4, 10, 10);
		set_idling(0, 0);
		send_item(OP_REPORT, 32'hffffffff, group_pool[2]);
		send_item(OP_REPORT, 32'h00000000, 32'hffffffff);
		send_item(OP_REPORT, 32'h12345678, 32'h00000000);
		send_item(OP_LEAVE, 32'h0, group_pool[2]);
		send_item(OP_LEAVE, 32'hffffffff, group_pool[3]);
		send_item(OP_REPORT, 32'h1, group_pool[2]);
		send_item(OP_LEAVE, 32'h0, 32'hffffffff);
		send_item(OP_QUERY, 32'h0a000005, 32'h0);
		send_item(OP_QUERY, 32'hffffffff, 32'hffffffff);
		repeat (3) send_item(OP_TICK, 32'h0, 32'h0);
		send_item(OP_QUERY, 32'h00000000, 32'h0);
		send_item(OP_LEAVE, 32'h0, 32'h00000000);
		repeat (9) send_item(OP_TICK, 32'hffffffff, 32'hffffffff);
	endtask

	// Fill every entry, then one more report that finds no room.
	task automatic test_table_full();
		set_config(32'h80000000, 7, 65535, 255, 255);
		set_idling(17, 17);
		for (int i = 0; i <= GROUPS; i++)
			send_item(OP_REPORT, $urandom, 32'he0000100 + 32'(i));
		send_item(OP_LEAVE, 32'h0, 32'he0000100);
	endtask

	task automatic test_no_idling();
		set_config(32'h0a000010, 2, 4, 10, 20);
		set_idling(0, 0);
		run_random(60);
	endtask

	task automatic test_sender_idle();
		set_config($urandom, 1, 5, 255, 255);
		set_idling(64, 0);
		run_random(50);
	endtask

	// Highest address: every foreign query wins the election.
	task automatic test_receiver_stall();
		set_config(32'hffffffff, 7, 4, 40, 10);
		set_idling(0, 64);
		run_random(50);
	endtask

	// Lowest address: no query can take the querier role away.
	task automatic test_both_idle();
		set_config(32'h00000000, 3, 6, 10, 30);
		set_idling(17, 17);
		run_random(50);
	endtask

	// Hold the receiver off while ticks and leaves keep coming, so the
	// output fills and the input stalls.
	task automatic test_backpressure();
		set_config(32'h0a000020, 4, 4, 100, 10);
		set_idling(0, 0);
		for (int i = 0; i < 10; i++)
			send_item(OP_REPORT, $urandom, group_pool[i]);
		hold_req = 1'b1;
		for (int i = 0; i < 10; i++)
			send_item(OP_LEAVE, $urandom, group_pool[i]);
		repeat (10) send_item(OP_TICK, $urandom, $urandom);
	endtask

	task automatic test_long_interval();
		set_config(32'h7fffffff, 1, 65535, 10, 10);
		set_idling(0, 0);
		run_random(10);
	endtask

	// Receiver: random stalls, or a long hold-off when asked.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_OFF;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	// Compare each accepted result beat with the oldest expectation; watch
	// for the design going quiet.
	always @(posedge clk) begin
		beat_t exp_beat;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (result_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d group %h",
					out_ch.result_kind, out_ch.result_group));
			end else begin
				exp_beat = result_q.pop_front();
				if (out_ch.result_kind !== exp_beat.kind)
					report_mismatch($sformatf("kind %0d, want %0d",
						out_ch.result_kind, exp_beat.kind));
				if (out_ch.result_group !== exp_beat.grp)
					report_mismatch($sformatf("group %h, want %h",
						out_ch.result_group, exp_beat.grp));
				if (out_ch.max_response_seconds !== exp_beat.mr)
					report_mismatch($sformatf("max response %0d, want %0d",
						out_ch.max_response_seconds, exp_beat.mr));
				if (out_ch.querier_now !== exp_beat.qn)
					report_mismatch($sformatf("querier flag %b, want %b",
						out_ch.querier_now, exp_beat.qn));
				if (out_ch.current_querier !== exp_beat.cq)
					report_mismatch($sformatf("querier %h, want %h",
						out_ch.current_querier, exp_beat.cq));
				if (out_ch.last_of_run !== exp_beat.last)
					report_mismatch($sformatf("last flag %b, want %b",
						out_ch.last_of_run, exp_beat.last));
			end
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		errors       = 0;
		quiet_cycles = 0;
		hold_req     = 1'b0;
		hold_left    = 0;
		set_idling(0, 0);
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		in_ch.valid          = 1'b0;
		in_ch.opcode         = '0;
		in_ch.source_address = '0;
		in_ch.group_address  = '0;
		out_ch.ready         = 1'b0;
		group_pool[0] = 32'h00000000;
		group_pool[1] = 32'hffffffff;
		for (int i = 2; i < 20; i++)
			group_pool[i] = $urandom;

		// Reset state of the predictor mirrors the block after reset.
		m_my_addr      = '0;
		m_robust       = 3'd2;
		m_qi           = 16'd125;
		m_qr_tenths    = 8'd100;
		m_lm_tenths    = 8'd10;
		m_querier      = 1'b1;
		m_querier_addr = '0;
		m_startup      = 1'b1;
		m_startup_left = 3'd1;
		m_general      = 1'b0;
		m_query_cnt    = 16'd31;
		m_other_cnt    = '0;
		for (int i = 0; i < GROUPS; i++) begin
			m_valid[i]        = 1'b0;
			m_group[i]        = '0;
			m_member_cnt[i]   = '0;
			m_lastmem_cnt[i]  = '0;
			m_lastmem_left[i] = '0;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();
		test_long_interval();
		drain();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
